@@ rtl/core/gfqm_pkg.sv @@
// ----------------------------------------------------------------------------
// gfqm_pkg
// Shared types, codes and result builders for the GPS fix quality monitor.
// ----------------------------------------------------------------------------
package gfqm_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic       REQ_SAMPLE = 1'b0;
    localparam logic       REQ_EOL    = 1'b1;

    localparam logic [1:0] KIND_CLOSE     = 2'd0;
    localparam logic [1:0] KIND_FIRST_FIX = 2'd1;
    localparam logic [1:0] KIND_NO_FIX    = 2'd2;

    localparam logic [1:0] REG_SAT_MIN    = 2'd0;
    localparam logic [1:0] REG_HDOP_LIMIT = 2'd1;
    localparam logic [1:0] REG_SACC_WARN  = 2'd2;
    localparam logic [1:0] REG_SACC_FAIL  = 2'd3;

    localparam logic [5:0]  SAT_MIN_RST    = 6'd5;
    localparam logic [13:0] HDOP_LIMIT_RST = 14'd500;
    localparam logic [15:0] SACC_WARN_RST  = 16'd100;
    localparam logic [15:0] SACC_FAIL_RST  = 16'd150;

    localparam logic [2:0] FIX_3D_MIN    = 3'd3;
    localparam logic [5:0] SEV_STEP      = 6'd10;
    localparam logic [5:0] SEV_SACC_FAIL = 6'd20;
    localparam logic [5:0] SEV_NO_FIX    = 6'd20;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  rx_index;
        logic [5:0]  sat_count;
        logic [13:0] hdop_val;
        logic [15:0] sacc_val;
        logic [2:0]  fix_kind;
        logic        boot_valid;
        logic [47:0] boot_time;
        logic [47:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  rx_id;
        logic [47:0] start_time;
        logic [47:0] stop_time;
        logic [5:0]  worst_sats;
        logic [13:0] worst_hdop;
        logic [15:0] worst_sacc;
        logic [5:0]  severity;
        logic [47:0] fix_time;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  sat_min;
        logic [13:0] hdop_limit;
        logic [15:0] sacc_warn;
        logic [15:0] sacc_fail;
    } cfg_t;

    typedef struct packed {
        logic [47:0] ep_start;
        logic [5:0]  min_sats;
        logic [13:0] max_hdop;
        logic [15:0] max_sacc;
        logic [47:0] fix_at;
    } ep_rec_t;

    typedef struct packed {
        logic ep_open;
        logic seen;
        logic found;
        logic non3d;
    } rx_flags_t;

    typedef struct packed {
        ep_rec_t   rec;
        rx_flags_t flags;
        logic      close_emit;
        logic      fix_emit;
    } eval_out_t;

    function automatic logic [5:0] close_severity(cfg_t cfg, ep_rec_t rec);
        logic [5:0] sev;
        sev = '0;
        if (rec.max_sacc > cfg.sacc_fail)
            sev = SEV_SACC_FAIL;
        else if (rec.max_sacc > cfg.sacc_warn)
            sev = SEV_STEP;
        if (rec.min_sats <= cfg.sat_min)
            sev = sev + SEV_STEP;
        if (rec.max_hdop >= cfg.hdop_limit)
            sev = sev + SEV_STEP;
        return sev;
    endfunction

    function automatic out_item_t close_item(logic [1:0] rx, ep_rec_t rec,
                                             logic [47:0] now, cfg_t cfg,
                                             logic is_last);
        out_item_t r;
        r.kind       = KIND_CLOSE;
        r.rx_id      = rx;
        r.start_time = rec.ep_start;
        r.stop_time  = now;
        r.worst_sats = rec.min_sats;
        r.worst_hdop = rec.max_hdop;
        r.worst_sacc = rec.max_sacc;
        r.severity   = close_severity(cfg, rec);
        r.fix_time   = '0;
        r.last       = is_last;
        return r;
    endfunction

endpackage

@@ rtl/core/gfqm_sample_eval.sv @@
// ----------------------------------------------------------------------------
// gfqm_sample_eval
// Judges one GPS sample against the thresholds and computes the new episode
// record, receiver flags and which results the sample raises.
// ----------------------------------------------------------------------------
module gfqm_sample_eval (
    input  gfqm_pkg::cfg_t      cfg,
    input  gfqm_pkg::in_item_t  item,
    input  gfqm_pkg::ep_rec_t   rec,
    input  gfqm_pkg::rx_flags_t flags,
    output gfqm_pkg::eval_out_t result
);
    import gfqm_pkg::*;

    logic bad;

    assign bad = (item.sat_count <= cfg.sat_min) || (item.hdop_val >= cfg.hdop_limit)
              || (item.sacc_val >= cfg.sacc_warn);

    always_comb
    begin
        result            = '0;
        result.rec        = rec;
        result.flags      = flags;
        result.flags.seen = 1'b1;

        if (!flags.ep_open)
        begin
            if (bad)
            begin
                result.flags.ep_open = 1'b1;
                result.rec.ep_start  = item.now_time;
                result.rec.min_sats  = item.sat_count;
                result.rec.max_hdop  = item.hdop_val;
                result.rec.max_sacc  = item.sacc_val;
            end
        end
        else if (bad)
        begin
            if (rec.min_sats > item.sat_count)
                result.rec.min_sats = item.sat_count;
            if (rec.max_hdop < item.hdop_val)
                result.rec.max_hdop = item.hdop_val;
            if (rec.max_sacc < item.sacc_val)
                result.rec.max_sacc = item.sacc_val;
        end
        else
        begin
            result.flags.ep_open = 1'b0;
            result.close_emit    = 1'b1;
        end

        if (!flags.found)
        begin
            if (item.fix_kind >= FIX_3D_MIN)
            begin
                if (item.boot_valid)
                begin
                    result.flags.found = 1'b1;
                    if (!flags.non3d)
                        result.rec.fix_at = '0;
                    else
                    begin
                        result.rec.fix_at = item.boot_time;
                        result.fix_emit   = 1'b1;
                    end
                end
            end
            else
                result.flags.non3d = 1'b1;
        end
        else if (item.boot_valid && (item.boot_time < rec.fix_at))
            result.flags.found = 1'b0;
    end

endmodule

@@ rtl/core/gps_fix_quality_monitor.sv @@
// ----------------------------------------------------------------------------
// gps_fix_quality_monitor
// Per-receiver bad-fix episode tracking and first 3D fix timing.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer
// apb       in   config register write/read, pready always high
// in        in   one GPS sample or end-of-log request (in_valid/in_ready)
// out       out  one result item (out_valid/out_ready)
//
// A sample is taken with its record read, then modified and written back in S_MOD;
// S_EMIT then pushes each result that it raises into the output register.
// End of log is accepted, then S_NOFIX scans every receiver for a missing fix and
// S_CL_RD scans for open episodes, with S_CL_OUT closing each one that it reads.
// Reset clears all flags at once; the record memory needs no clearing pass.
// A stalled output holds the walk; the next item is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module gps_fix_quality_monitor #(
    parameter int NUM_RX = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gfqm_pkg::PADDR_W-1:0]  paddr,
    input  logic [gfqm_pkg::PDATA_W-1:0]  pwdata,
    output logic [gfqm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gfqm_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gfqm_pkg::out_item_t           out_data
);
    import gfqm_pkg::*;

    localparam int IDX_W = (NUM_RX > 1) ? $clog2(NUM_RX) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_RX - 1);
    localparam logic [4:0] NUM_RX_V = 5'(NUM_RX);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MOD    = 6'b000010,
        S_EMIT   = 6'b000100,
        S_NOFIX  = 6'b001000,
        S_CL_RD  = 6'b010000,
        S_CL_OUT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    cfg_t              cfg_reg;
    in_item_t          in_reg;
    logic [IDX_W-1:0]  walk_reg, walk_next;
    logic [NUM_RX-1:0] open_reg, open_next;
    logic [NUM_RX-1:0] seen_reg, seen_next;
    logic [NUM_RX-1:0] found_reg, found_next;
    logic [NUM_RX-1:0] non3d_reg, non3d_next;
    out_item_t         pend_a_reg, pend_b_reg;
    logic              pend_a_v_reg, pend_a_v_next;
    logic              pend_b_v_reg, pend_b_v_next;
    out_item_t         out_reg;
    logic              out_valid_reg;

    ep_rec_t           ep_mem [NUM_RX];
    ep_rec_t           rd_data_reg;
    logic              mem_re, mem_we;
    logic [IDX_W-1:0]  rd_addr;

    logic              cfg_wr;
    logic              can_push, push_v;
    out_item_t         push_item;
    logic [IDX_W-1:0]  in_addr;
    logic              in_range;
    rx_flags_t         cur_flags;
    eval_out_t         ev;
    logic [NUM_RX-1:0] cand;
    logic              cand_above, open_above;
    out_item_t         fix_item, nofix_item;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sat_min    <= SAT_MIN_RST;
            cfg_reg.hdop_limit <= HDOP_LIMIT_RST;
            cfg_reg.sacc_warn  <= SACC_WARN_RST;
            cfg_reg.sacc_fail  <= SACC_FAIL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SAT_MIN:    cfg_reg.sat_min    <= pwdata[5:0];
                REG_HDOP_LIMIT: cfg_reg.hdop_limit <= pwdata[13:0];
                REG_SACC_WARN:  cfg_reg.sacc_warn  <= pwdata[15:0];
                REG_SACC_FAIL:  cfg_reg.sacc_fail  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAT_MIN:    prdata = {26'd0, cfg_reg.sat_min};
            REG_HDOP_LIMIT: prdata = {18'd0, cfg_reg.hdop_limit};
            REG_SACC_WARN:  prdata = {16'd0, cfg_reg.sacc_warn};
            REG_SACC_FAIL:  prdata = {16'd0, cfg_reg.sacc_fail};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // episode record memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ep_mem[in_addr] <= ev.rec;
        if (mem_re)
            rd_data_reg <= ep_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sample evaluation
    // ------------------------------------------------------------------
    assign in_addr  = IDX_W'(in_reg.rx_index);
    assign in_range = {3'd0, in_data.rx_index} < NUM_RX_V;

    assign cur_flags.ep_open = open_reg[in_addr];
    assign cur_flags.seen    = seen_reg[in_addr];
    assign cur_flags.found   = found_reg[in_addr];
    assign cur_flags.non3d   = non3d_reg[in_addr];

    gfqm_sample_eval u_eval (
        .cfg    (cfg_reg),
        .item   (in_reg),
        .rec    (rd_data_reg),
        .flags  (cur_flags),
        .result (ev)
    );

    always_comb
    begin
        fix_item            = '0;
        fix_item.kind       = KIND_FIRST_FIX;
        fix_item.rx_id      = in_reg.rx_index;
        fix_item.stop_time  = in_reg.now_time;
        fix_item.fix_time   = in_reg.boot_time;
        fix_item.last       = 1'b1;
    end

    // ------------------------------------------------------------------
    // end-of-log walk helpers
    // ------------------------------------------------------------------
    assign cand       = seen_reg & ~found_reg;
    assign cand_above = |((cand >> walk_reg) >> 1);
    assign open_above = |((open_reg >> walk_reg) >> 1);

    always_comb
    begin
        nofix_item          = '0;
        nofix_item.kind     = KIND_NO_FIX;
        nofix_item.rx_id    = 2'(walk_reg);
        nofix_item.severity = SEV_NO_FIX;
        nofix_item.last     = !cand_above && !(|open_reg);
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign can_push = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        walk_next     = walk_reg;
        open_next     = open_reg;
        seen_next     = seen_reg;
        found_next    = found_reg;
        non3d_next    = non3d_reg;
        pend_a_v_next = pend_a_v_reg;
        pend_b_v_next = pend_b_v_reg;
        push_v        = 1'b0;
        push_item     = pend_a_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = walk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == REQ_EOL)
                    begin
                        walk_next  = '0;
                        state_next = S_NOFIX;
                    end
                    else if (in_range)
                    begin
                        mem_re     = 1'b1;
                        rd_addr    = IDX_W'(in_data.rx_index);
                        state_next = S_MOD;
                    end
                end
            end

            S_MOD:
            begin
                mem_we              = 1'b1;
                open_next[in_addr]  = ev.flags.ep_open;
                seen_next[in_addr]  = ev.flags.seen;
                found_next[in_addr] = ev.flags.found;
                non3d_next[in_addr] = ev.flags.non3d;
                pend_a_v_next       = ev.close_emit;
                pend_b_v_next       = ev.fix_emit;
                state_next          = (ev.close_emit || ev.fix_emit) ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                if (can_push)
                begin
                    push_v = 1'b1;
                    if (pend_a_v_reg)
                    begin
                        push_item     = pend_a_reg;
                        pend_a_v_next = 1'b0;
                        if (!pend_b_v_reg)
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        push_item     = pend_b_reg;
                        pend_b_v_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            S_NOFIX:
            begin
                if (!cand[walk_reg] || can_push)
                begin
                    if (cand[walk_reg])
                    begin
                        push_v    = 1'b1;
                        push_item = nofix_item;
                    end
                    if (walk_reg == LAST_IDX)
                    begin
                        walk_next  = '0;
                        state_next = S_CL_RD;
                    end
                    else
                        walk_next = walk_reg + 1'b1;
                end
            end

            S_CL_RD:
            begin
                if (open_reg[walk_reg])
                begin
                    mem_re     = 1'b1;
                    state_next = S_CL_OUT;
                end
                else if (walk_reg == LAST_IDX)
                    state_next = S_IDLE;
                else
                    walk_next = walk_reg + 1'b1;
            end

            S_CL_OUT:
            begin
                if (can_push)
                begin
                    push_v              = 1'b1;
                    push_item           = close_item(2'(walk_reg), rd_data_reg,
                                                     in_reg.now_time, cfg_reg,
                                                     !open_above);
                    open_next[walk_reg] = 1'b0;
                    if (walk_reg == LAST_IDX)
                        state_next = S_IDLE;
                    else
                    begin
                        walk_next  = walk_reg + 1'b1;
                        state_next = S_CL_RD;
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_reg      <= '0;
            open_reg      <= '0;
            seen_reg      <= '0;
            found_reg     <= '0;
            non3d_reg     <= '0;
            pend_a_v_reg  <= 1'b0;
            pend_b_v_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_reg     <= walk_next;
            open_reg     <= open_next;
            seen_reg     <= seen_next;
            found_reg    <= found_next;
            non3d_reg    <= non3d_next;
            pend_a_v_reg <= pend_a_v_next;
            pend_b_v_reg <= pend_b_v_next;
            if (push_v)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (state_reg == S_MOD)
        begin
            pend_a_reg <= close_item(in_reg.rx_index, rd_data_reg, in_reg.now_time,
                                     cfg_reg, !ev.fix_emit);
            pend_b_reg <= fix_item;
        end
        if (push_v)
            out_reg <= push_item;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_mod_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> ($past(state_reg) == S_IDLE))
        else $error("record update not preceded by its read");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_v |-> (!out_valid_reg || out_ready))
        else $error("result pushed over a waiting result");

    a_close_is_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CL_OUT) |-> open_reg[walk_reg])
        else $error("closing an episode that is not open");

    a_emit_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pend_a_v_reg || pend_b_v_reg))
        else $error("emit state with nothing pending");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!pend_a_v_reg && !pend_b_v_reg))
        else $error("new transfer taken while results are pending");
`endif

endmodule
